[rtl/core/sag_pkg.sv]
// ----------------------------------------------------------------------------
// sag_pkg
// Shared types and codes for the sorted adjacency graph store.
// ----------------------------------------------------------------------------
package sag_pkg;

  localparam int IdW     = 8;
  localparam int FuncW   = 2;
  localparam int StatusW = 3;
  localparam int DegOutW = 5;
  localparam int EdgeW   = 12;

  typedef logic [FuncW-1:0]   func_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [IdW-1:0]     id_t;

  localparam func_t FN_ADD    = 2'd0;
  localparam func_t FN_REMOVE = 2'd1;
  localparam func_t FN_TEST   = 2'd2;
  localparam func_t FN_DEGREE = 2'd3;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_NOCHANGE = 3'd1;
  localparam status_t ST_RANGE    = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_LOOP     = 3'd4;

endpackage

[rtl/core/sag_if.sv]
// ----------------------------------------------------------------------------
// sag request / response channels
// Valid/ready channels carrying graph requests and their results.
// ----------------------------------------------------------------------------
interface sag_req_if;
  logic            valid;
  logic            ready;
  sag_pkg::func_t  func;
  sag_pkg::id_t    node_a;
  sag_pkg::id_t    node_b;
  modport source (output valid, func, node_a, node_b, input ready);
  modport sink   (input valid, func, node_a, node_b, output ready);
endinterface

interface sag_rsp_if;
  logic                            valid;
  logic                            ready;
  sag_pkg::status_t                status;
  logic                            edge_present;
  logic [sag_pkg::DegOutW-1:0]     degree_a;
  logic [sag_pkg::EdgeW-1:0]       edge_total;
  logic [sag_pkg::DegOutW-1:0]     max_deg;
  modport source (output valid, status, edge_present, degree_a, edge_total, max_deg,
                  input ready);
  modport sink   (input valid, status, edge_present, degree_a, edge_total, max_deg,
                  output ready);
endinterface

[rtl/core/sag_slot_mem.sv]
// ----------------------------------------------------------------------------
// sag_slot_mem
// Neighbour slot storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sag_slot_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/sag_deg_mem.sv]
// ----------------------------------------------------------------------------
// sag_deg_mem
// Per-node degree table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sag_deg_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 5
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/sorted_adjacency_graph_store_core.sv]
// ----------------------------------------------------------------------------
// sorted_adjacency_graph_store_core
// Undirected graph store with sorted neighbour lists, degrees, edge count and
// maximum degree, driven by a small sequencer over one list engine.
//
//   channel   dir  fields
//   in_req    in   func, node_a, node_b
//   out_rsp   out  status, edge_present, degree_a, edge_total, max_deg
//
// After reset the degree table is cleared; no request is taken until the clear is done.
// An add or remove walks list a and shifts it as needed, then does the same for
// list b, one slot at a time through the slot memory read port; a test walks
// list a only. A remove from a node at the maximum degree adds a rescan of
// the degree table. A result waiting in the output register does not block
// the next request.
// ----------------------------------------------------------------------------
module sorted_adjacency_graph_store_core #(
  parameter int NODES      = 256,
  parameter int MAX_DEGREE = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  sag_req_if.sink      in_req,
  sag_rsp_if.source    out_rsp
);
  localparam int NW = $clog2(NODES);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int SD = NODES * MAX_DEGREE;
  localparam int AW = $clog2(SD);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RDA, S_RDB, S_SCAN, S_SCMP, S_DECIDE, S_SHIFT, S_SHW,
    S_LDONE, S_UPD, S_UPD2, S_RSC, S_RSCEND, S_FIN
  } state_t;

  state_t                  state_r;
  sag_pkg::func_t          func_r;
  logic [NW-1:0]           a_r, b_r, cur_r, val_r, clr_r, rsc_r;
  logic                    err_r, phase_r, hit_r, pend_r, present_r;
  sag_pkg::status_t        st_r;
  logic [DW-1:0]           da_r, db_r, dcur_r, idx_r, pos_r, max_r, scan_m_r;
  logic [sag_pkg::EdgeW-1:0] edges_r;

  logic                    out_valid_r, out_present_r;
  sag_pkg::status_t        out_status_r;
  logic [sag_pkg::DegOutW-1:0] out_deg_r, out_max_r;
  logic [sag_pkg::EdgeW-1:0]   out_edges_r;

  logic          slot_we;
  logic [AW-1:0] slot_waddr, slot_raddr;
  logic [NW-1:0] slot_wdata, slot_rdata;
  logic          deg_we;
  logic [NW-1:0] deg_waddr, deg_raddr;
  logic [DW-1:0] deg_wdata, deg_rdata;

  logic          a_ok, b_ok, is_add;
  logic [NW-1:0] in_a, in_b;
  logic [DW-1:0] idx_m1, idx_p1, nda, ndb;

  function automatic logic [AW-1:0] slot_addr(logic [NW-1:0] n, logic [DW-1:0] i);
    return AW'(n) * AW'(MAX_DEGREE) + AW'(i[IW-1:0]);
  endfunction

  function automatic logic [DW-1:0] dmax(logic [DW-1:0] x, logic [DW-1:0] y);
    return (x > y) ? x : y;
  endfunction

  sag_slot_mem #(.DEPTH(SD), .WIDTH(NW)) u_slots (
    .clk, .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  sag_deg_mem #(.DEPTH(NODES), .WIDTH(DW)) u_deg (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata)
  );

  assign a_ok   = 32'(in_req.node_a) < NODES;
  assign b_ok   = 32'(in_req.node_b) < NODES;
  assign in_a   = NW'(in_req.node_a);
  assign in_b   = NW'(in_req.node_b);
  assign is_add = (func_r == sag_pkg::FN_ADD);
  assign idx_m1 = idx_r - DW'(1);
  assign idx_p1 = idx_r + DW'(1);
  assign nda    = is_add ? da_r + DW'(1) : da_r - DW'(1);
  assign ndb    = is_add ? db_r + DW'(1) : db_r - DW'(1);

  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.edge_present = out_present_r;
  assign out_rsp.degree_a     = out_deg_r;
  assign out_rsp.edge_total   = out_edges_r;
  assign out_rsp.max_deg      = out_max_r;

  // memory port steering
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_addr(cur_r, idx_r);
    slot_wdata = slot_rdata;
    slot_raddr = slot_addr(cur_r, idx_r);
    deg_we     = 1'b0;
    deg_waddr  = a_r;
    deg_wdata  = nda;
    deg_raddr  = in_a;
    case (state_r)
      S_CLR: begin
        deg_we    = 1'b1;
        deg_waddr = clr_r;
        deg_wdata = '0;
      end
      S_RDA: deg_raddr = b_r;
      S_SHIFT: begin
        if (is_add) begin
          slot_raddr = slot_addr(cur_r, idx_m1);
          if (idx_r == pos_r) begin
            slot_we    = 1'b1;
            slot_waddr = slot_addr(cur_r, pos_r);
            slot_wdata = val_r;
          end
        end else begin
          slot_raddr = slot_addr(cur_r, idx_p1);
        end
      end
      S_SHW:  slot_we = 1'b1;
      S_UPD:  deg_we = 1'b1;
      S_UPD2: begin
        deg_we    = 1'b1;
        deg_waddr = b_r;
        deg_wdata = db_r;
      end
      S_RSC:  deg_raddr = rsc_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      edges_r     <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the final state reloads the output register itself
      if (out_valid_r && out_rsp.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + NW'(1);
          if (clr_r == NW'(NODES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_req.valid) begin
            func_r    <= in_req.func;
            a_r       <= in_a;
            b_r       <= in_b;
            present_r <= 1'b0;
            if (in_req.func == sag_pkg::FN_DEGREE) begin
              st_r  <= a_ok ? sag_pkg::ST_OK : sag_pkg::ST_RANGE;
              err_r <= 1'b0;
            end else if (!a_ok || !b_ok) begin
              st_r  <= sag_pkg::ST_RANGE;
              err_r <= 1'b1;
            end else if (in_req.node_a == in_req.node_b) begin
              st_r  <= sag_pkg::ST_LOOP;
              err_r <= 1'b1;
            end else begin
              st_r  <= sag_pkg::ST_OK;
              err_r <= 1'b0;
            end
            if (a_ok) begin
              state_r <= S_RDA;
            end else begin
              da_r    <= '0;
              state_r <= S_FIN;
            end
          end
        end
        S_RDA: begin
          da_r <= deg_rdata;
          if (err_r || func_r == sag_pkg::FN_DEGREE) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_RDB;
          end
        end
        S_RDB: begin
          db_r    <= deg_rdata;
          phase_r <= 1'b0;
          cur_r   <= a_r;
          val_r   <= b_r;
          dcur_r  <= da_r;
          idx_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (idx_r == dcur_r) begin
            pos_r   <= idx_r;
            hit_r   <= 1'b0;
            state_r <= S_DECIDE;
          end else begin
            state_r <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (slot_rdata < val_r) begin
            idx_r   <= idx_p1;
            state_r <= S_SCAN;
          end else begin
            pos_r   <= idx_r;
            hit_r   <= (slot_rdata == val_r);
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          // insert shifts down from the tail, delete shifts up from the hit
          idx_r <= is_add ? dcur_r : pos_r;
          if (phase_r) begin
            state_r <= S_SHIFT;
          end else begin
            present_r <= hit_r;
            case (func_r)
              sag_pkg::FN_ADD: begin
                if (hit_r) begin
                  st_r    <= sag_pkg::ST_NOCHANGE;
                  state_r <= S_FIN;
                end else if (32'(da_r) >= MAX_DEGREE || 32'(db_r) >= MAX_DEGREE) begin
                  st_r    <= sag_pkg::ST_FULL;
                  state_r <= S_FIN;
                end else begin
                  state_r <= S_SHIFT;
                end
              end
              sag_pkg::FN_REMOVE: begin
                if (!hit_r) begin
                  st_r    <= sag_pkg::ST_NOCHANGE;
                  state_r <= S_FIN;
                end else begin
                  state_r <= S_SHIFT;
                end
              end
              default: state_r <= S_FIN;
            endcase
          end
        end
        S_SHIFT: begin
          if (is_add) begin
            if (idx_r == pos_r) begin
              state_r <= S_LDONE;
            end else begin
              state_r <= S_SHW;
            end
          end else if (idx_p1 < dcur_r) begin
            state_r <= S_SHW;
          end else begin
            state_r <= S_LDONE;
          end
        end
        S_SHW: begin
          idx_r   <= is_add ? idx_m1 : idx_p1;
          state_r <= S_SHIFT;
        end
        S_LDONE: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
            cur_r   <= b_r;
            val_r   <= a_r;
            dcur_r  <= db_r;
            idx_r   <= '0;
            state_r <= S_SCAN;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          da_r    <= nda;
          db_r    <= ndb;
          state_r <= S_UPD2;
        end
        S_UPD2: begin
          if (is_add) begin
            edges_r <= edges_r + sag_pkg::EdgeW'(1);
            max_r   <= dmax(max_r, dmax(da_r, db_r));
            state_r <= S_FIN;
          end else begin
            edges_r <= edges_r - sag_pkg::EdgeW'(1);
            if (max_r != '0 && (da_r == max_r - DW'(1) || db_r == max_r - DW'(1))) begin
              rsc_r    <= '0;
              pend_r   <= 1'b0;
              scan_m_r <= '0;
              state_r  <= S_RSC;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_RSC: begin
          pend_r <= 1'b1;
          if (pend_r) begin
            scan_m_r <= dmax(scan_m_r, deg_rdata);
          end
          rsc_r <= rsc_r + NW'(1);
          if (rsc_r == NW'(NODES - 1)) begin
            state_r <= S_RSCEND;
          end
        end
        S_RSCEND: begin
          max_r   <= dmax(scan_m_r, deg_rdata);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= st_r;
            out_present_r <= present_r;
            out_deg_r     <= sag_pkg::DegOutW'(da_r);
            out_edges_r   <= edges_r;
            out_max_r     <= sag_pkg::DegOutW'(max_r);
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_deg_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> da_r <= max_r)
    else $error("degree of node a above maximum degree");

  a_slot_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    slot_we |-> (state_r == S_SHW || state_r == S_SHIFT))
    else $error("slot write outside shift sequence");

  a_edges_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> $stable(edges_r))
    else $error("edge count changed without an update");

  a_full_not_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == sag_pkg::ST_FULL |-> !out_present_r)
    else $error("full list reported with edge present");
endmodule
